@@ hdl/cfrc_pkg.sv @@
package cfrc_pkg;

    // Words in one configuration frame.
    localparam int WORDS_PER_FRAME = 123;

    // Field widths.
    localparam int COORD_W  = 10;
    localparam int ROW_W    = 11;
    localparam int OFFSET_W = 32;
    localparam int WORD_W   = 11;
    localparam int COUNT_W  = 3;
    localparam int REGION_W = 3;
    localparam int FPR_W    = 20;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;

    // Region indexes at the ends of the stack.
    localparam logic [REGION_W-1:0] REGION_TOP    = 3'd0;
    localparam logic [REGION_W-1:0] REGION_BOTTOM = 3'd4;

    // Register defaults.
    localparam logic [COORD_W-1:0] BOUND4_RESET  = 10'd59;
    localparam logic [COORD_W-1:0] BOUND3_RESET  = 10'd119;
    localparam logic [COORD_W-1:0] BOUND2_RESET  = 10'd179;
    localparam logic [COORD_W-1:0] BOUND1_RESET  = 10'd239;
    localparam logic [COORD_W-1:0] MAX_ROW_RESET = 10'd299;
    localparam logic [COORD_W-1:0] MIN_COL_RESET = 10'd0;
    localparam logic [COORD_W-1:0] FPC_RESET     = 10'd64;
    localparam logic [FPR_W-1:0]   FPR_RESET     = 20'd16384;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_BOUND4  = 3'd0,
        REG_BOUND3  = 3'd1,
        REG_BOUND2  = 3'd2,
        REG_BOUND1  = 3'd3,
        REG_MAX_ROW = 3'd4,
        REG_MIN_COL = 3'd5,
        REG_FPC     = 3'd6,
        REG_FPR     = 3'd7
    } t_reg_addr;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_AX,
        S_BX,
        S_AW,
        S_BW,
        S_SW,
        S_BASE,
        S_EMIT
    } t_state;

endpackage

@@ hdl/cfrc_mul.sv @@
module cfrc_mul
    import cfrc_pkg::*;
(
    input  logic [OFFSET_W-1:0] i_a,
    input  logic [OFFSET_W-1:0] i_b,
    output logic [OFFSET_W-1:0] o_p
);

    // Shared multiplier; only the low word is kept, so products wrap modulo 2^32.
    assign o_p = OFFSET_W'(i_a * i_b);

endmodule

@@ hdl/config_frame_range_calc_top.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_x_low, i_y_low, i_x_high, i_y_high
// output    out        o_out_valid / i_out_stall  o_first_frame_offset .. o_last_range
// config    in         psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A rectangle passes the steps on the one shared multiplier (column frames, word
// scaling, region stride, region base) and then gives one region word per cycle while
// the output is not stalled; the input stalls until the sequencer is idle again.
// An out-of-range rectangle skips the multiplier and gives a single error word.
// Synchronous active-low reset returns the sequencer to idle and the registers to
// their defaults. A stalled output word holds the sequencer in the emit state.
module config_frame_range_calc_top
    import cfrc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input channel.
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [COORD_W-1:0]         i_x_low,
    input  logic signed [ROW_W-1:0]    i_y_low,
    input  logic [COORD_W-1:0]         i_x_high,
    input  logic signed [ROW_W-1:0]    i_y_high,
    // Output channel.
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OFFSET_W-1:0] o_first_frame_offset,
    output logic signed [OFFSET_W-1:0] o_last_frame_offset,
    output logic [WORD_W-1:0]          o_first_word,
    output logic [WORD_W-1:0]          o_last_word,
    output logic [COUNT_W-1:0]         o_region_count,
    output logic                       o_range_error,
    output logic                       o_last_range,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready
);

    localparam logic [WORD_W-1:0]   WORD_MAX = WORD_W'(WORDS_PER_FRAME - 1);
    localparam logic [OFFSET_W-1:0] WPF      = OFFSET_W'(WORDS_PER_FRAME);

    // Configuration registers.
    logic [COORD_W-1:0] r_bound4, r_bound3, r_bound2, r_bound1, r_max_row;
    logic [COORD_W-1:0] r_min_col, r_fpc;
    logic [FPR_W-1:0]   r_fpr;

    // Sequencer and working registers.
    t_state                 r_state, n_state;
    logic [COORD_W-1:0]     r_xl, r_xh;
    logic [ROW_W-1:0]       r_yl, r_yh;
    logic [REGION_W-1:0]    r_rt, r_rb, r_r;
    logic                   r_err;
    logic [OFFSET_W-1:0]    r_ax, r_bx, r_sw, r_base;

    // Output register.
    logic                   r_out_valid;
    logic [OFFSET_W-1:0]    r_first_off, r_last_off;
    logic [WORD_W-1:0]      r_first_word, r_last_word;
    logic [COUNT_W-1:0]     r_count;
    logic                   r_out_err, r_out_last;

    logic                   w_accept, w_cfg_wr, w_out_free, w_emit;
    logic                   w_in_err;
    logic [REGION_W-1:0]    w_rt, w_rb_raw, w_rb;
    logic [OFFSET_W-1:0]    w_mul_a, w_mul_b, w_mul_p;
    logic [COORD_W-1:0]     w_top, w_top_below;
    logic [ROW_W-1:0]       w_bottom;
    logic [ROW_W:0]         w_diff_h, w_diff_l;
    logic                   w_first, w_last, w_yh_bot, w_yl_bot;
    logic [COUNT_W-1:0]     w_count;
    logic [WORD_W-1:0]      w_fw, w_lw;

    // Region of a row by ordered tests against the bounds.
    function automatic logic [REGION_W-1:0] f_region(
        input logic [ROW_W-1:0]   y,
        input logic [COORD_W-1:0] b4,
        input logic [COORD_W-1:0] b3,
        input logic [COORD_W-1:0] b2,
        input logic [COORD_W-1:0] b1
    );
        logic signed [ROW_W:0] ys;
        ys = $signed({y[ROW_W-1], y});
        if (ys <= $signed({2'b00, b4})) begin
            return 3'd4;
        end else if (ys <= $signed({2'b00, b3})) begin
            return 3'd3;
        end else if (ys <= $signed({2'b00, b2})) begin
            return 3'd2;
        end else if (ys <= $signed({2'b00, b1})) begin
            return 3'd1;
        end
        return REGION_TOP;
    endfunction

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel & penable & pwrite & pready;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    // Row checks and region indexes of an arriving rectangle.
    assign w_in_err = i_y_low[ROW_W-1] |
                      ($signed({i_y_high[ROW_W-1], i_y_high}) > $signed({2'b00, r_max_row}));
    assign w_rt     = f_region(i_y_high, r_bound4, r_bound3, r_bound2, r_bound1);
    assign w_rb_raw = f_region(i_y_low, r_bound4, r_bound3, r_bound2, r_bound1);
    assign w_rb     = (w_rb_raw < w_rt) ? w_rt : w_rb_raw;

    // Configuration write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound4  <= BOUND4_RESET;
            r_bound3  <= BOUND3_RESET;
            r_bound2  <= BOUND2_RESET;
            r_bound1  <= BOUND1_RESET;
            r_max_row <= MAX_ROW_RESET;
            r_min_col <= MIN_COL_RESET;
            r_fpc     <= FPC_RESET;
            r_fpr     <= FPR_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg_addr'(paddr[ADDR_W-1:2]))
                REG_BOUND4:  r_bound4  <= pwdata[COORD_W-1:0];
                REG_BOUND3:  r_bound3  <= pwdata[COORD_W-1:0];
                REG_BOUND2:  r_bound2  <= pwdata[COORD_W-1:0];
                REG_BOUND1:  r_bound1  <= pwdata[COORD_W-1:0];
                REG_MAX_ROW: r_max_row <= pwdata[COORD_W-1:0];
                REG_MIN_COL: r_min_col <= pwdata[COORD_W-1:0];
                REG_FPC:     r_fpc     <= pwdata[COORD_W-1:0];
                REG_FPR:     r_fpr     <= pwdata[FPR_W-1:0];
            endcase
        end
    end

    // Configuration read.
    always_comb begin
        unique case (t_reg_addr'(paddr[ADDR_W-1:2]))
            REG_BOUND4:  prdata = DATA_W'(r_bound4);
            REG_BOUND3:  prdata = DATA_W'(r_bound3);
            REG_BOUND2:  prdata = DATA_W'(r_bound2);
            REG_BOUND1:  prdata = DATA_W'(r_bound1);
            REG_MAX_ROW: prdata = DATA_W'(r_max_row);
            REG_MIN_COL: prdata = DATA_W'(r_min_col);
            REG_FPC:     prdata = DATA_W'(r_fpc);
            REG_FPR:     prdata = DATA_W'(r_fpr);
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_AX: begin
                w_mul_a = OFFSET_W'(r_xl) - OFFSET_W'(r_min_col);
                w_mul_b = OFFSET_W'(r_fpc);
            end
            S_BX: begin
                w_mul_a = OFFSET_W'(r_xh) - OFFSET_W'(r_min_col);
                w_mul_b = OFFSET_W'(r_fpc);
            end
            S_AW: begin
                w_mul_a = r_ax;
                w_mul_b = WPF;
            end
            S_BW: begin
                w_mul_a = r_bx + OFFSET_W'(r_fpc) - OFFSET_W'(1);
                w_mul_b = WPF;
            end
            S_SW: begin
                w_mul_a = OFFSET_W'(r_fpr);
                w_mul_b = WPF;
            end
            S_BASE: begin
                w_mul_a = r_sw;
                w_mul_b = OFFSET_W'(r_rt);
            end
            S_IDLE, S_EMIT: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    cfrc_mul u_mul (
        .i_a (w_mul_a),
        .i_b (w_mul_b),
        .o_p (w_mul_p)
    );

    // Top row of the current region and of the region below it.
    always_comb begin
        unique case (r_r)
            3'd4:    w_top = r_bound4;
            3'd3:    w_top = r_bound3;
            3'd2:    w_top = r_bound2;
            3'd1:    w_top = r_bound1;
            default: w_top = r_max_row;
        endcase
        unique case (r_r)
            3'd3:    w_top_below = r_bound4;
            3'd2:    w_top_below = r_bound3;
            3'd1:    w_top_below = r_bound2;
            default: w_top_below = r_bound1;
        endcase
    end

    // Word range of the current region.
    always_comb begin
        w_bottom = (r_r >= REGION_BOTTOM) ? '0 : (ROW_W'(w_top_below) + ROW_W'(1));
        w_diff_h = {2'b00, w_top} - {r_yh[ROW_W-1], r_yh};
        w_diff_l = {2'b00, w_top} - {r_yl[ROW_W-1], r_yl};
        w_yh_bot = ({r_yh[ROW_W-1], r_yh} == {1'b0, w_bottom});
        w_yl_bot = ({r_yl[ROW_W-1], r_yl} == {1'b0, w_bottom});
        w_first  = (r_r == r_rt);
        w_last   = (r_r == r_rb);
        w_count  = COUNT_W'(r_rb - r_rt) + COUNT_W'(1);
        // The top range of several starts at the last word when y_high sits on
        // its region's bottom row.
        if (!w_first) begin
            w_fw = '0;
        end else if (!w_last && w_yh_bot) begin
            w_fw = WORD_MAX;
        end else begin
            w_fw = {w_diff_h[WORD_W-2:0], 1'b0};
        end
        if (!w_last) begin
            w_lw = WORD_MAX;
        end else if (w_yl_bot) begin
            w_lw = WORD_MAX;
        end else begin
            w_lw = {w_diff_l[WORD_W-2:0], 1'b1};
        end
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and emit strobe.
    always_comb begin
        n_state = r_state;
        w_emit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_in_err ? S_EMIT : S_AX;
                end
            end
            S_AX:   n_state = S_BX;
            S_BX:   n_state = S_AW;
            S_AW:   n_state = S_BW;
            S_BW:   n_state = S_SW;
            S_SW:   n_state = S_BASE;
            S_BASE: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (r_err || w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    // Captured rectangle and product registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_xl  <= i_x_low;
            r_xh  <= i_x_high;
            r_yl  <= i_y_low;
            r_yh  <= i_y_high;
            r_rt  <= w_rt;
            r_rb  <= w_rb;
            r_r   <= w_rt;
            r_err <= w_in_err;
        end else if (w_emit) begin
            r_r <= r_r + REGION_W'(1);
        end
        unique case (r_state)
            S_AX:   r_ax <= w_mul_p;
            S_BX:   r_bx <= w_mul_p;
            S_AW:   r_ax <= w_mul_p;
            S_BW:   r_bx <= w_mul_p;
            S_SW:   r_sw <= w_mul_p;
            S_BASE: r_base <= w_mul_p;
            S_EMIT: begin
                if (w_emit) begin
                    r_base <= r_base + r_sw;
                end
            end
            S_IDLE: ;
        endcase
    end

    // Output word valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            if (r_err) begin
                r_first_off  <= '0;
                r_last_off   <= '0;
                r_first_word <= '0;
                r_last_word  <= '0;
                r_count      <= '0;
                r_out_err    <= 1'b1;
                r_out_last   <= 1'b1;
            end else begin
                r_first_off  <= r_ax + r_base;
                r_last_off   <= r_bx + r_base;
                r_first_word <= w_fw;
                r_last_word  <= w_lw;
                r_count      <= w_count;
                r_out_err    <= 1'b0;
                r_out_last   <= w_last;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_first_frame_offset = $signed(r_first_off);
    assign o_last_frame_offset  = $signed(r_last_off);
    assign o_first_word         = r_first_word;
    assign o_last_word          = r_last_word;
    assign o_region_count       = r_count;
    assign o_range_error        = r_out_err;
    assign o_last_range         = r_out_last;

endmodule
